/* sv/mba_pkg.sv */
`timescale 1ns / 1ps
package mba_pkg;

    localparam int SLOT_W   = 6;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int GROUP_W  = 3;
    localparam int PRICE_W  = 32;
    localparam int VOL_W    = 32;

    // Number of slots that a six-bit slot field can name.
    localparam int SLOT_SPACE = 1 << SLOT_W;

    localparam logic [VOL_W-1:0] VOL_MAX = '1;

    // Session groups.
    localparam logic [GROUP_W-1:0] GRP_NONE     = 3'd0;
    localparam logic [GROUP_W-1:0] GRP_END_2300 = 3'd1;
    localparam logic [GROUP_W-1:0] GRP_END_2330 = 3'd2;
    localparam logic [GROUP_W-1:0] GRP_END_0100 = 3'd3;
    localparam logic [GROUP_W-1:0] GRP_END_0230 = 3'd4;
    localparam logic [GROUP_W-1:0] GRP_TREASURY = 3'd5;

    typedef struct packed {
        logic [SLOT_W-1:0]   symbol_slot;
        logic [GROUP_W-1:0]  session_group;
        logic [HOUR_W-1:0]   tick_hour;
        logic [MINUTE_W-1:0] tick_minute;
        logic [PRICE_W-1:0]  last_price;
        logic [VOL_W-1:0]    tick_volume;
    } tick_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   bar_slot;
        logic [HOUR_W-1:0]   bar_hour;
        logic [MINUTE_W-1:0] bar_minute;
        logic [PRICE_W-1:0]  open_price;
        logic [PRICE_W-1:0]  high_price;
        logic [PRICE_W-1:0]  low_price;
        logic [PRICE_W-1:0]  close_price;
        logic [VOL_W-1:0]    bar_volume;
    } bar_t;

    // One table entry: the bar under construction in a slot.
    typedef struct packed {
        logic [HOUR_W-1:0]   open_hour;
        logic [MINUTE_W-1:0] open_minute;
        logic [PRICE_W-1:0]  first_price;
        logic [PRICE_W-1:0]  top_price;
        logic [PRICE_W-1:0]  bottom_price;
        logic [PRICE_W-1:0]  latest_price;
        logic [VOL_W-1:0]    volume_sum;
    } bar_entry_t;

    // Write-back control from the update logic to the table.
    typedef struct packed {
        logic wr_en;
        logic clr_en;
    } tbl_ctl_t;

    function automatic logic at_time(input logic [HOUR_W-1:0] h,
                                     input logic [MINUTE_W-1:0] m,
                                     input logic [HOUR_W-1:0] th,
                                     input logic [MINUTE_W-1:0] tm);
        return (h == th) && (m == tm);
    endfunction

    // True when a bar at h:m closes the session of group g.
    function automatic logic session_end(input logic [GROUP_W-1:0] g,
                                         input logic [HOUR_W-1:0] h,
                                         input logic [MINUTE_W-1:0] m);
        logic hit;
        hit = 1'b0;
        case (g)
            GRP_END_2300: hit = (h == 5'd23);
            GRP_END_2330: hit = at_time(h, m, 5'd23, 6'd30);
            GRP_END_0100: hit = (h == 5'd1);
            GRP_END_0230: hit = at_time(h, m, 5'd2, 6'd30);
            GRP_TREASURY: hit = at_time(h, m, 5'd15, 6'd15);
            default:      hit = 1'b0;
        endcase
        return hit || ((g != GRP_TREASURY) && at_time(h, m, 5'd15, 6'd0));
    endfunction

endpackage

/* sv/mba_stream_if.sv */
`timescale 1ns / 1ps
interface mba_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* sv/mba_bar_table.sv */
`timescale 1ns / 1ps
module mba_bar_table #(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_en,
    input  logic [IDX_W-1:0]    rd_idx,
    output mba_pkg::bar_entry_t rd_entry,
    output logic                rd_open,
    input  mba_pkg::tbl_ctl_t   ctl,
    input  mba_pkg::bar_entry_t wr_entry
);
    import mba_pkg::*;

    bar_entry_t             bar_mem_reg [DEPTH];
    bar_entry_t             rd_data_reg;
    logic [IDX_W-1:0]       rd_idx_reg;
    logic [DEPTH-1:0]       open_reg;
    bar_entry_t             fwd_entry_reg;
    logic [IDX_W-1:0]       fwd_idx_reg;
    logic                   fwd_valid_reg;

    // The write address is always the entry read for the word now in the update stage.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= bar_mem_reg[rd_idx];
        end
        if (ctl.wr_en)
        begin
            bar_mem_reg[rd_idx_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg    <= '0;
            open_reg      <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                rd_idx_reg <= rd_idx;
            end
            if (ctl.wr_en)
            begin
                open_reg[rd_idx_reg] <= 1'b1;
                fwd_valid_reg        <= 1'b1;
            end
            else if (ctl.clr_en)
            begin
                open_reg[rd_idx_reg] <= 1'b0;
            end
        end
    end

    // The last write is kept so that a read issued in the same cycle sees it.
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            fwd_entry_reg <= wr_entry;
            fwd_idx_reg   <= rd_idx_reg;
        end
    end

    always_comb
    begin
        if (fwd_valid_reg && (fwd_idx_reg == rd_idx_reg))
        begin
            rd_entry = fwd_entry_reg;
        end
        else
        begin
            rd_entry = rd_data_reg;
        end
        rd_open = open_reg[rd_idx_reg];
    end

endmodule

/* sv/mba_bar_update.sv */
`timescale 1ns / 1ps
module mba_bar_update (
    input  mba_pkg::tick_t      tick,
    input  mba_pkg::bar_entry_t cur,
    input  logic                cur_open,
    output mba_pkg::bar_entry_t nxt,
    output mba_pkg::tbl_ctl_t   ctl,
    output logic                emit
);
    import mba_pkg::*;

    logic             same_minute;
    logic             stub;
    logic             sess_end;
    logic [VOL_W:0]   vol_sum;

    always_comb
    begin
        same_minute = cur_open && (cur.open_hour == tick.tick_hour)
                      && (cur.open_minute == tick.tick_minute);
        stub        = at_time(cur.open_hour, cur.open_minute, 5'd11, 6'd30)
                      || at_time(cur.open_hour, cur.open_minute, 5'd10, 6'd15);
        sess_end    = session_end(tick.session_group, cur.open_hour, cur.open_minute);
        vol_sum     = {1'b0, cur.volume_sum} + {1'b0, tick.tick_volume};

        nxt.open_hour    = tick.tick_hour;
        nxt.open_minute  = tick.tick_minute;
        nxt.first_price  = tick.last_price;
        nxt.top_price    = tick.last_price;
        nxt.bottom_price = tick.last_price;
        nxt.latest_price = tick.last_price;
        nxt.volume_sum   = tick.tick_volume;
        ctl.wr_en        = 1'b1;
        ctl.clr_en       = 1'b0;
        emit             = 1'b0;

        if (same_minute)
        begin
            nxt.open_hour    = cur.open_hour;
            nxt.open_minute  = cur.open_minute;
            nxt.first_price  = cur.first_price;
            nxt.top_price    = (tick.last_price > cur.top_price) ?
                               tick.last_price : cur.top_price;
            nxt.bottom_price = (tick.last_price < cur.bottom_price) ?
                               tick.last_price : cur.bottom_price;
            nxt.volume_sum   = vol_sum[VOL_W] ? VOL_MAX : vol_sum[VOL_W-1:0];
        end
        else if (cur_open && !stub && sess_end)
        begin
            // The tick is dropped and the slot is left without an open bar.
            ctl.wr_en  = 1'b0;
            ctl.clr_en = 1'b1;
        end
        else
        begin
            emit = cur_open && !stub && (cur.latest_price != '0);
        end
    end

endmodule

/* sv/minute_bar_aggregator.sv */
`timescale 1ns / 1ps
// Minute bar aggregator. Ticks arrive on the tick channel and finished one-minute
// open/high/low/close/volume bars leave on the bar channel, at most one bar per tick.
// The block takes one tick word in every clock cycle while the bar channel does not stall,
// with no gaps for ticks of the same symbol. The bar word that a tick closes is built
// in the update stage and registered in the output register before it is presented.
// The update stage rests on the per-slot bar table, a synchronous memory with one read
// and one write port: a tick is looked up in the cycle it is accepted, updated and written
// back when the update stage moves on, and the entry just written is forwarded to a lookup
// of the same slot in that same cycle. The open flag of every slot sits in flip-flops that
// reset clears at once, so the block is ready straight after reset with no clearing
// pass. Ticks whose slot is not below SYMBOL_SLOTS are accepted and discarded. When the
// bar channel stalls, one bar waits in the output register and the pipeline holds.
module minute_bar_aggregator #(
    parameter int SYMBOL_SLOTS = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    mba_stream_if.sink   tick,
    mba_stream_if.source bar
);
    import mba_pkg::*;

    // Only slots that the slot field can name need storage.
    localparam int TABLE_DEPTH = (SYMBOL_SLOTS < SLOT_SPACE) ? SYMBOL_SLOTS : SLOT_SPACE;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    tick_t            in_word;
    logic [15:0]      slot_ext;
    logic             in_range;
    logic             accept;
    logic             advance;
    logic             commit;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;

    tick_t            s1_tick_reg;
    logic             s1_valid_reg;

    bar_entry_t       cur_entry;
    logic             cur_open;
    bar_entry_t       nxt_entry;
    tbl_ctl_t         upd_ctl;
    tbl_ctl_t         tbl_ctl;
    logic             emit;

    bar_t             bar_word_reg;
    logic             bar_valid_reg;

    // The update stage moves on whenever the output register is free or being emptied.
    always_comb
    begin
        in_word    = tick.payload;
        slot_ext   = {10'd0, in_word.symbol_slot};
        in_range   = (slot_ext < 16'(SYMBOL_SLOTS));
        advance    = !bar_valid_reg || bar.ready;
        tick.ready = !s1_valid_reg || advance;
        accept     = tick.valid && tick.ready;
        rd_en      = accept && in_range;
        rd_idx     = slot_ext[IDX_W-1:0];
        commit     = s1_valid_reg && advance;
        tbl_ctl.wr_en  = commit && upd_ctl.wr_en;
        tbl_ctl.clr_en = commit && upd_ctl.clr_en;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= in_range;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            s1_tick_reg <= in_word;
        end
    end

    mba_bar_table #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_idx   (rd_idx),
        .rd_entry (cur_entry),
        .rd_open  (cur_open),
        .ctl      (tbl_ctl),
        .wr_entry (nxt_entry)
    );

    mba_bar_update u_update (
        .tick     (s1_tick_reg),
        .cur      (cur_entry),
        .cur_open (cur_open),
        .nxt      (nxt_entry),
        .ctl      (upd_ctl),
        .emit     (emit)
    );

    // Output register: a finished bar waits here while the next tick is worked on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bar_valid_reg <= 1'b0;
        end
        else if (commit && emit)
        begin
            bar_valid_reg <= 1'b1;
        end
        else if (bar.ready)
        begin
            bar_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit && emit)
        begin
            bar_word_reg.bar_slot    <= s1_tick_reg.symbol_slot;
            bar_word_reg.bar_hour    <= cur_entry.open_hour;
            bar_word_reg.bar_minute  <= cur_entry.open_minute;
            bar_word_reg.open_price  <= cur_entry.first_price;
            bar_word_reg.high_price  <= cur_entry.top_price;
            bar_word_reg.low_price   <= cur_entry.bottom_price;
            bar_word_reg.close_price <= cur_entry.latest_price;
            bar_word_reg.bar_volume  <= cur_entry.volume_sum;
        end
    end

    assign bar.valid   = bar_valid_reg;
    assign bar.payload = bar_word_reg;

endmodule

/* sv/mba_checker.sv */
`timescale 1ns / 1ps
module mba_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          tick_valid,
    input logic          tick_ready,
    input logic          bar_valid,
    input logic          bar_ready,
    input mba_pkg::bar_t bar_payload
);
    import mba_pkg::*;

    // A stalled bar word stays put.
    a_bar_hold: assert property (@(posedge clk) disable iff (!rst_n)
        bar_valid && !bar_ready |=> bar_valid && $stable(bar_payload))
        else $error("bar word changed while stalled");

    // A bar word that appears on an empty output was caused by a tick accepted
    // earlier and held in the update stage register.
    a_bar_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(bar_valid) |-> $past(tick_valid && tick_ready, 2))
        else $error("bar word without a preceding tick");

    // With the output register empty the block always takes a tick.
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !bar_valid |-> tick_ready)
        else $error("tick refused with the output empty");

    // A bar being taken frees the pipeline in the same cycle.
    a_ready_drain: assert property (@(posedge clk) disable iff (!rst_n)
        bar_valid && bar_ready |-> tick_ready)
        else $error("tick refused while a bar word is taken");

endmodule

bind minute_bar_aggregator mba_checker u_mba_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick_valid  (tick.valid),
    .tick_ready  (tick.ready),
    .bar_valid   (bar.valid),
    .bar_ready   (bar.ready),
    .bar_payload (bar.payload)
);
